@@ hdl/rvt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rvt_pkg
// Shared types and constants of the 3-D voxel traversal block.
// ----------------------------------------------------------------------------
package rvt_pkg;

  localparam int AXES      = 3;
  localparam int OP_W      = 3;
  localparam int DIV_STEPS = 32;

  localparam logic [OP_W-1:0] OP_LAST = OP_W'(2 * AXES - 1);

  localparam logic        FUNC_START = 1'b0;
  localparam logic        FUNC_STEP  = 1'b1;
  localparam logic [15:0] START_T_RESET = 16'd1;

  typedef struct packed {
    logic            load_ray;
    logic            step;
    logic            div_start;
    logic            div_write;
    logic [OP_W-1:0] op;
    logic            out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

@@ hdl/rvt_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rvt_in_if / rvt_out_if
// Valid/ready channels for ray commands and traversal results.
// ----------------------------------------------------------------------------
interface rvt_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;

  modport source (output valid, func, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, func, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface rvt_out_if;
  logic               valid;
  logic               ready;
  logic        [31:0] hit_t;
  logic signed [15:0] cell_x;
  logic signed [15:0] cell_y;
  logic signed [15:0] cell_z;

  modport source (output valid, hit_t, cell_x, cell_y, cell_z, input ready);
  modport sink   (input valid, hit_t, cell_x, cell_y, cell_z, output ready);
endinterface
`default_nettype wire

@@ hdl/rvt_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rvt_div
// Restoring divider, one quotient bit per cycle, 32-bit by 16-bit unsigned.
// ----------------------------------------------------------------------------
module rvt_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [15:0] den,
  output logic             done,
  output logic [31:0]      quot
);
  import rvt_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic [31:0]      n;
  logic [16:0]      rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [16:0]      trial;
  logic             fits;

  assign trial = {rem[15:0], n[31]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n    <= num;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      n    <= {n[30:0], 1'b0};
      rem  <= fits ? trial - {1'b0, den} : trial;
      quot <= {quot[30:0], fits};
    end
  end
endmodule
`default_nettype wire

@@ hdl/rvt_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rvt_datapath
// Ray state, axis choice, crossing update, divider and output word register.
// ----------------------------------------------------------------------------
module rvt_datapath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire rvt_pkg::cmd_t  cmd,
  output rvt_pkg::status_t    status,
  input  wire logic           cfg_we,
  input  wire logic [15:0]    cfg_data,
  rvt_in_if.sink              in,
  rvt_out_if.source           out
);
  import rvt_pkg::*;

  logic [15:0] start_t;
  logic [15:0] cell_pos   [AXES];
  logic [31:0] next_cross [AXES];
  logic [31:0] cross_step [AXES];
  logic [15:0] frac       [AXES];
  logic [15:0] mag        [AXES];
  logic        step_neg   [AXES];
  logic        active     [AXES];
  logic [31:0] current_t;

  logic [31:0] org [AXES];
  logic [15:0] dir [AXES];

  logic [1:0]  div_axis;
  logic [16:0] gap;
  logic [31:0] div_num;
  logic        div_done;
  logic [31:0] quot;

  logic        pick [AXES];
  logic [1:0]  sel;
  logic        any;
  logic [32:0] sum;
  logic [31:0] sat;

  logic        out_valid;

  assign org[0] = in.origin_x;
  assign org[1] = in.origin_y;
  assign org[2] = in.origin_z;
  assign dir[0] = in.dir_x;
  assign dir[1] = in.dir_y;
  assign dir[2] = in.dir_z;

  assign div_axis = cmd.op[2:1];

  always_comb begin
    if (step_neg[div_axis]) begin
      gap = (frac[div_axis] == 16'd0) ? 17'h10000 : {1'b0, frac[div_axis]};
    end else begin
      gap = 17'h10000 - {1'b0, frac[div_axis]};
    end
    div_num = cmd.op[0] ? {gap, 15'd0} : 32'h8000_0000;
  end

  rvt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (mag[div_axis]),
    .done  (div_done),
    .quot  (quot)
  );

  always_comb begin
    pick[0] = active[0] && (!active[1] || next_cross[0] < next_cross[1])
                        && (!active[2] || next_cross[0] < next_cross[2]);
    pick[1] = !pick[0] && active[1] && (!active[2] || next_cross[1] < next_cross[2]);
    pick[2] = !pick[0] && !pick[1] && active[2];
    any     = pick[0] || pick[1] || pick[2];
    sel     = pick[0] ? 2'd0 : (pick[1] ? 2'd1 : 2'd2);
    sum     = {1'b0, next_cross[sel]} + {1'b0, cross_step[sel]};
    sat     = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_t   <= START_T_RESET;
      current_t <= '0;
      for (int k = 0; k < AXES; k++) begin
        cell_pos[k]   <= '0;
        next_cross[k] <= '0;
        cross_step[k] <= '0;
        step_neg[k]   <= 1'b0;
        active[k]     <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        start_t <= cfg_data;
      end
      if (cmd.load_ray) begin
        current_t <= {16'd0, start_t};
        for (int k = 0; k < AXES; k++) begin
          cell_pos[k]   <= org[k][31:16];
          next_cross[k] <= '0;
          cross_step[k] <= '0;
          step_neg[k]   <= dir[k][15];
          active[k]     <= dir[k] != 16'd0;
        end
      end
      if (cmd.div_write && active[div_axis]) begin
        if (cmd.op[0]) begin
          next_cross[div_axis] <= quot;
        end else begin
          cross_step[div_axis] <= quot;
        end
      end
      if (cmd.step && any) begin
        current_t       <= next_cross[sel];
        next_cross[sel] <= sat;
        cell_pos[sel]   <= step_neg[sel] ? cell_pos[sel] - 16'd1 : cell_pos[sel] + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_ray) begin
      for (int k = 0; k < AXES; k++) begin
        frac[k] <= org[k][15:0];
        mag[k]  <= dir[k][15] ? 16'd0 - dir[k] : dir[k];
      end
    end
  end

  // result of a step leaves with the updated state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.step && any) begin
        out.hit_t <= next_cross[sel];
        out.cell_x <= (sel == 2'd0) ? (step_neg[0] ? cell_pos[0] - 16'd1 : cell_pos[0] + 16'd1)
                                    : cell_pos[0];
        out.cell_y <= (sel == 2'd1) ? (step_neg[1] ? cell_pos[1] - 16'd1 : cell_pos[1] + 16'd1)
                                    : cell_pos[1];
        out.cell_z <= (sel == 2'd2) ? (step_neg[2] ? cell_pos[2] - 16'd1 : cell_pos[2] + 16'd1)
                                    : cell_pos[2];
      end else begin
        out.hit_t  <= current_t;
        out.cell_x <= cell_pos[0];
        out.cell_y <= cell_pos[1];
        out.cell_z <= cell_pos[2];
      end
    end
  end

  assign out.valid       = out_valid;
  assign status.out_free = !out_valid || out.ready;
  assign status.div_done = div_done;
endmodule
`default_nettype wire

@@ hdl/rvt_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rvt_ctrl
// Sequencer: accepts words, runs six divisions per ray start, loads results.
// ----------------------------------------------------------------------------
module rvt_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             in_func,
  output logic                  in_ready,
  input  wire rvt_pkg::status_t status,
  output rvt_pkg::cmd_t         cmd
);
  import rvt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_DIV   = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t          state, state_next;
  logic [OP_W-1:0] op, op_next;

  always_comb begin
    state_next = state;
    op_next    = op;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.op     = op;
    unique case (state)
      S_IDLE: begin
        in_ready = status.out_free;
        if (in_valid && status.out_free) begin
          if (in_func == FUNC_STEP) begin
            cmd.step     = 1'b1;
            cmd.out_load = 1'b1;
          end else begin
            cmd.load_ray = 1'b1;
            op_next      = '0;
            state_next   = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.div_write = 1'b1;
          if (op == OP_LAST) begin
            state_next = S_OUT;
          end else begin
            op_next    = op + 1'b1;
            state_next = S_ISSUE;
          end
        end
      end
      S_OUT: begin
        cmd.out_load = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end
endmodule
`default_nettype wire

@@ hdl/ray_voxel_traversal_3d.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ray_voxel_traversal_3d
// Amanatides-Woo grid walk along a ray in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// A step word (func 1) is handled in the cycle it is accepted and its result word
// is available the next cycle; a new word is accepted whenever the block is idle
// and the output register is free. A start word (func 0) runs six divisions (per
// axis, the per-cell t and the first crossing) on one shared restoring divider at
// one bit per cycle, and accepts no new word until its result has been loaded.
// start_t may be written through cfg_we/cfg_data while the block is idle.
module ray_voxel_traversal_3d (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data,
  rvt_in_if.sink           in,
  rvt_out_if.source        out
);
  import rvt_pkg::*;

  cmd_t    cmd;
  status_t status;

  rvt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in.valid),
    .in_func  (in.func),
    .in_ready (in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  rvt_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in       (in),
    .out      (out)
  );
endmodule
`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3-D voxel traversal block: drives start and
// step words with random gaps, predicts each result word and compares it.
// ----------------------------------------------------------------------------
module tb;
  import rvt_pkg::*;

  typedef struct packed {
    logic        func;
    logic [31:0] ox, oy, oz;
    logic [15:0] dx, dy, dz;
  } ray_cmd_t;

  typedef struct packed {
    logic [31:0] t;
    logic [15:0] cx, cy, cz;
  } walk_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_data = 16'd0;

  rvt_in_if  in_ch ();
  rvt_out_if out_ch ();

  ray_voxel_traversal_3d u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in(in_ch.sink), .out(out_ch.source)
  );

  always #5 clk = ~clk;

  ray_cmd_t  cmd_q[$];
  walk_res_t walk_expect_q[$];
  int        errors = 0;
  int        idle_cycles = 0;
  bit        calm = 1'b0;
  int        ready_pct = 80;

  // predictor state
  logic [31:0] m_start_t;
  logic [15:0] m_cell[3];
  logic [31:0] m_next[3];
  logic [31:0] m_step[3];
  logic        m_neg[3];
  logic        m_act[3];
  logic [31:0] m_t;

  function automatic void load_axis(int k, logic [31:0] o, logic [15:0] d);
    logic [16:0] a;
    logic [16:0] gap;
    a = d[15] ? 17'(17'h10000 - {1'b0, d}) : {1'b0, d};
    m_cell[k] = o[31:16];
    if (a == 0) begin
      m_act[k] = 0; m_neg[k] = 0; m_step[k] = 0; m_next[k] = 0;
    end else begin
      m_act[k] = 1;
      m_neg[k] = d[15];
      m_step[k] = 32'((64'd1 << 31) / a);
      if (d[15]) gap = (o[15:0] == 0) ? 17'h10000 : {1'b0, o[15:0]};
      else gap = 17'h10000 - {1'b0, o[15:0]};
      m_next[k] = 32'(({47'd0, gap} << 15) / a);
    end
  endfunction

  function automatic void advance_axis(int k);
    logic [32:0] s;
    s = {1'b0, m_next[k]} + {1'b0, m_step[k]};
    m_t = m_next[k];
    m_next[k] = s[32] ? 32'hFFFFFFFF : s[31:0];
    m_cell[k] = m_neg[k] ? m_cell[k] - 16'd1 : m_cell[k] + 16'd1;
  endfunction

  function automatic walk_res_t predict_walk(ray_cmd_t c);
    walk_res_t r;
    if (c.func == FUNC_START) begin
      load_axis(0, c.ox, c.dx);
      load_axis(1, c.oy, c.dy);
      load_axis(2, c.oz, c.dz);
      m_t = m_start_t;
    end else begin
      if (m_act[0] && (!m_act[1] || m_next[0] < m_next[1])
          && (!m_act[2] || m_next[0] < m_next[2])) advance_axis(0);
      else if (m_act[1] && (!m_act[2] || m_next[1] < m_next[2])) advance_axis(1);
      else if (m_act[2]) advance_axis(2);
    end
    r.t = m_t; r.cx = m_cell[0]; r.cy = m_cell[1]; r.cz = m_cell[2];
    return r;
  endfunction

  function automatic logic [15:0] rand_dir();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7FFF;
      3: return 16'(1 + $urandom_range(0, 3));
      4: return -16'(1 + $urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_org();
    case ($urandom_range(0, 5))
      0: return {16'($urandom), 16'h0000};
      1: return {16'h7FFF, 16'($urandom)};
      2: return {16'h8000, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        walk_expect_q.push_back(predict_walk(cmd_q.pop_front()));
      end
      if (cmd_q.size() > 0 && (calm || $urandom_range(0, 99) >= 20)) begin
        in_ch.valid    <= 1'b1;
        in_ch.func     <= cmd_q[0].func;
        in_ch.origin_x <= cmd_q[0].ox;
        in_ch.origin_y <= cmd_q[0].oy;
        in_ch.origin_z <= cmd_q[0].oz;
        in_ch.dir_x    <= cmd_q[0].dx;
        in_ch.dir_y    <= cmd_q[0].dy;
        in_ch.dir_z    <= cmd_q[0].dz;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ready side of the result channel
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm || ($urandom_range(0, 99) < ready_pct);
  end

  // monitor
  always @(posedge clk) begin
    walk_res_t got, exp_r;
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.hit_t, out_ch.cell_x, out_ch.cell_y, out_ch.cell_z};
        if (walk_expect_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: %h", got);
        end else begin
          exp_r = walk_expect_q.pop_front();
          if (got !== exp_r) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: t %h/%h cell %h %h %h / %h %h %h",
                       exp_r.t, got.t, exp_r.cx, exp_r.cy, exp_r.cz,
                       got.cx, got.cy, got.cz);
          end
        end
      end
      if (idle_cycles > 5000) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic push_cmd(logic f, logic [31:0] ox, oy, oz, logic [15:0] dx, dy, dz);
    ray_cmd_t c;
    c = '{func: f, ox: ox, oy: oy, oz: oz, dx: dx, dy: dy, dz: dz};
    cmd_q.push_back(c);
  endtask

  task automatic push_steps(int n);
    repeat (n) push_cmd(FUNC_STEP, $urandom, $urandom, $urandom,
                        16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    wait (cmd_q.size() == 0 && !in_ch.valid && walk_expect_q.size() == 0);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_start_t(logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    m_start_t = {16'd0, v};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.func = 1'b0;
    in_ch.origin_x = '0; in_ch.origin_y = '0; in_ch.origin_z = '0;
    in_ch.dir_x = '0; in_ch.dir_y = '0; in_ch.dir_z = '0;
    out_ch.ready = 1'b0;
    m_start_t = {16'd0, START_T_RESET};
    for (int k = 0; k < 3; k++) begin
      m_cell[k] = 0; m_next[k] = 0; m_step[k] = 0; m_neg[k] = 0; m_act[k] = 0;
    end
    m_t = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: step before start, zero ray, extremes, ties
    push_steps(2);
    push_cmd(FUNC_START, 32'h0001_8000, 32'h0, 32'hFFFF_0000, 16'h0, 16'h0, 16'h0);
    push_steps(2);
    push_cmd(FUNC_START, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'h7FFF, 16'h8000, 16'h0001);
    push_steps(4);
    push_cmd(FUNC_START, 32'h0, 32'h0, 32'h0, 16'h4000, 16'h4000, 16'h4000);
    push_steps(4);
    push_cmd(FUNC_START, 32'h0000_8000, 32'h0, 32'hFFFF_FFFF, 16'hFFFF, 16'h0, 16'hFFFF);
    push_steps(4);
    push_cmd(FUNC_START, 32'h7FFF_0000, 32'h8000_0001, 32'h0, 16'h0001, 16'hFFFF, 16'h0);
    push_steps(3);
    drain();
    write_start_t(16'hFFFF);
    push_cmd(FUNC_START, 32'h0, 32'h0, 32'h0, 16'h1234, 16'h0, 16'h0);
    push_steps(2);
    drain();
    write_start_t(16'h0000);
    push_cmd(FUNC_START, $urandom, $urandom, $urandom, 16'h7FFF, 16'h7FFF, 16'h0);
    push_steps(2);
    drain();

    // random: rays followed by runs of steps
    for (int ph = 0; ph < 4; ph++) begin
      calm = (ph == 2);
      ready_pct = calm ? 100 : 80;
      write_start_t(ph == 3 ? 16'($urandom) : (ph == 0 ? 16'd1 : 16'(ph * 1000)));
      for (int r = 0; r < 10; r++) begin
        if ($urandom_range(0, 9) == 0) push_steps(1);
        push_cmd(FUNC_START, rand_org(), rand_org(), rand_org(),
                 rand_dir(), rand_dir(), rand_dir());
        push_steps($urandom_range(2, 18));
      end
      drain();
    end

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire
